[design/uart_rx_line_fifo_unit_defines.svh]
// assertion macros for the line fifo unit
`ifndef UART_RX_LINE_FIFO_UNIT_DEFINES_SVH
`define UART_RX_LINE_FIFO_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// consequent checked in the same cycle as the antecedent
`define URLF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urlf check failed");
// consequent checked in the cycle after the antecedent
`define URLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urlf check failed");
`else
`define URLF_ASSERT_SAME(label, clk, rst, ante, cons)
`define URLF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/urlf_pkg.sv]
package urlf_pkg;

   // ring geometry
   localparam int DEPTH = 256;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = PTR_W + 2;

   // line copy limit
   localparam int LIM_W = 7;
   localparam int MAX_LINE_OUT = 64;
   localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
   localparam logic [LIM_W-1:0] COPY_LIMIT_RESET = LIM_W'(63);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // line terminators
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_LINE = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic       strobe;
      logic       found;
      logic [7:0] line_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] fill;
   } back_status_type;

   // advance a ring pointer with wrap
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

[design/urlf_front.sv]
module urlf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic [7:0]                req_rx_byte,
   input  urlf_pkg::queue_status_type q_status,
   output logic                      q_push,
   output urlf_pkg::cmd_type         q_cmd
);

   logic              hold_valid_ff;
   logic              hold_valid_in;
   urlf_pkg::cmd_type hold_cmd_ff;
   urlf_pkg::cmd_type hold_cmd_in;
   logic              accept;
   logic              move;

   // hand the held item to the queue when it has room
   assign move   = hold_valid_ff && !q_status.full;
   assign busy   = hold_valid_ff && q_status.full;
   assign accept = start && !busy;
   assign q_push = move;
   assign q_cmd  = hold_cmd_ff;

   // classify the incoming item
   always_comb begin
      hold_cmd_in = hold_cmd_ff;
      if (accept) begin
         hold_cmd_in.kind = req_func ? urlf_pkg::CMD_LINE : urlf_pkg::CMD_PUSH;
         hold_cmd_in.data = req_func ? 8'h00 : req_rx_byte;
      end
   end

   assign hold_valid_in = accept || (hold_valid_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

[design/urlf_cmd_queue.sv]
module urlf_cmd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  urlf_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output urlf_pkg::cmd_type          pop_cmd,
   output urlf_pkg::queue_status_type status
);

   urlf_pkg::cmd_type                entry_ff [urlf_pkg::QUEUE_DEPTH];
   logic [urlf_pkg::QIDX_W-1:0]      wr_ptr_ff;
   logic [urlf_pkg::QIDX_W-1:0]      wr_ptr_in;
   logic [urlf_pkg::QIDX_W-1:0]      rd_ptr_ff;
   logic [urlf_pkg::QIDX_W-1:0]      rd_ptr_in;
   logic [urlf_pkg::QCNT_W-1:0]      count_ff;
   logic [urlf_pkg::QCNT_W-1:0]      count_in;
   logic                             do_push;
   logic                             do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == urlf_pkg::QCNT_W'(urlf_pkg::QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == urlf_pkg::QIDX_W'(urlf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == urlf_pkg::QIDX_W'(urlf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/urlf_back.sv]
module urlf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  urlf_pkg::queue_status_type      q_status,
   input  urlf_pkg::cmd_type               q_cmd,
   output logic                            q_pop,
   input  logic [urlf_pkg::LIM_W-1:0]      copy_limit,
   output urlf_pkg::rsp_type               rsp,
   output urlf_pkg::back_status_type       status
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SCAN_RD  = 5'b00010,
      ST_SCAN_CHK = 5'b00100,
      ST_COPY_RD  = 5'b01000,
      ST_COPY_OUT = 5'b10000
   } back_state_type;

   back_state_type                 state_ff;
   back_state_type                 state_in;
   logic [urlf_pkg::PTR_W-1:0]     rp_ff;
   logic [urlf_pkg::PTR_W-1:0]     rp_in;
   logic [urlf_pkg::PTR_W-1:0]     wp_ff;
   logic [urlf_pkg::PTR_W-1:0]     wp_in;
   logic [urlf_pkg::CNT_W-1:0]     fill_ff;
   logic [urlf_pkg::CNT_W-1:0]     fill_in;
   logic [urlf_pkg::PTR_W-1:0]     idx_ff;
   logic [urlf_pkg::PTR_W-1:0]     idx_in;
   logic [urlf_pkg::CNT_W-1:0]     len_ff;
   logic [urlf_pkg::CNT_W-1:0]     len_in;
   logic [urlf_pkg::LIM_W-1:0]     cnt_ff;
   logic [urlf_pkg::LIM_W-1:0]     cnt_in;
   logic [urlf_pkg::LIM_W-1:0]     num_ff;
   logic [urlf_pkg::LIM_W-1:0]     num_in;
   urlf_pkg::rsp_type              rsp_ff;
   urlf_pkg::rsp_type              rsp_in;
   logic [7:0]                     rd_data_ff;
   logic [7:0]                     mem [urlf_pkg::DEPTH];
   logic                           mem_we;
   logic [urlf_pkg::CNT_W-1:0]     len_next;
   logic [urlf_pkg::LIM_W-1:0]     lim;
   logic [urlf_pkg::SUM_W-1:0]     rp_sum;
   logic [urlf_pkg::SUM_W-1:0]     rp_wrap;
   logic                           is_last;

   assign rsp         = rsp_ff;
   assign status.fill = fill_ff;
   assign q_pop       = (state_ff == ST_IDLE) && q_status.valid;

   // clamp the copy limit into one to the output maximum
   always_comb begin
      if (copy_limit == '0) begin
         lim = urlf_pkg::LIM_W'(1);
      end else if (copy_limit > urlf_pkg::LIM_W'(urlf_pkg::MAX_LINE_OUT)) begin
         lim = urlf_pkg::LIM_W'(urlf_pkg::MAX_LINE_OUT);
      end else begin
         lim = copy_limit;
      end
   end

   assign len_next = len_ff + 1'b1;
   assign is_last  = ((cnt_ff + 1'b1) == num_ff);

   // read pointer after the whole line is consumed
   assign rp_sum  = urlf_pkg::SUM_W'(rp_ff) + urlf_pkg::SUM_W'(len_ff);
   assign rp_wrap = (rp_sum >= urlf_pkg::SUM_W'(urlf_pkg::DEPTH)) ?
                    rp_sum - urlf_pkg::SUM_W'(urlf_pkg::DEPTH) : rp_sum;

   // sequencer
   always_comb begin
      state_in = state_ff;
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      mem_we   = 1'b0;
      rsp_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               if (q_cmd.kind == urlf_pkg::CMD_PUSH) begin
                  if (fill_ff < urlf_pkg::CNT_W'(urlf_pkg::DEPTH)) begin
                     mem_we  = 1'b1;
                     wp_in   = urlf_pkg::ring_next(wp_ff);
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  rsp_in.strobe = 1'b1;
                  rsp_in.last   = 1'b1;
               end else begin
                  idx_in   = rp_ff;
                  len_in   = '0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            len_in = len_next;
            if (rd_data_ff inside {urlf_pkg::CH_CR, urlf_pkg::CH_LF}) begin
               num_in = (urlf_pkg::CMP_W'(len_next) < urlf_pkg::CMP_W'(lim)) ?
                        urlf_pkg::LIM_W'(len_next) : lim;
               idx_in   = rp_ff;
               cnt_in   = '0;
               state_in = ST_COPY_RD;
            end else if (len_next == fill_ff) begin
               rsp_in.strobe = 1'b1;
               rsp_in.last   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in   = urlf_pkg::ring_next(idx_ff);
               state_in = ST_SCAN_RD;
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_OUT;
         end
         ST_COPY_OUT: begin
            rsp_in.strobe    = 1'b1;
            rsp_in.found     = 1'b1;
            rsp_in.line_byte = rd_data_ff;
            rsp_in.last      = is_last;
            if (is_last) begin
               rp_in    = urlf_pkg::PTR_W'(rp_wrap);
               fill_in  = fill_ff - len_ff;
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               idx_in   = urlf_pkg::ring_next(idx_ff);
               state_in = ST_COPY_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rp_ff    <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         rsp_ff   <= rsp_in;
      end
   end

   // scan and copy working registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      cnt_ff <= cnt_in;
      num_ff <= num_in;
   end

   // byte store, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= q_cmd.data;
      end
      rd_data_ff <= mem[idx_ff];
   end

endmodule

[design/uart_rx_line_fifo_unit.sv]
// receive ring buffer that hands out whole text lines
//
// input channel: an item is taken at a clock edge with start high and busy
// low. req_func 0 pushes req_rx_byte into the ring (dropped when the ring
// holds all 256 bytes); req_func 1 asks for one line ending in CR or LF.
// a push gives no result. a line request gives one rsp_strobe pulse per
// line byte (rsp_found 1, at most copy_limit bytes, clamped to 1..64,
// last marked by rsp_last), or a single pulse, rsp_found 0 and rsp_last 1,
// when no terminator is buffered. the whole line is always consumed.
// flow: items pass a front hold register and a two-entry command queue;
// a push is stored, and a request on an empty ring is answered, as the
// back end pops it. a line request steps through scan read and scan check
// states per scanned byte, then copy read and copy out states per
// delivered byte, as the byte store has a single registered read port.
// busy rises only while the queue is full behind a long line request.
// csr channel: csr_copy_limit is written when csr_valid and csr_ready are
// high; csr_ready is always high. write it only while the block is idle.
// reset: pointers and count go to zero, copy limit to 63, store contents
// stay unknown. the receiver cannot stall: each result shows for one cycle.
`include "uart_rx_line_fifo_unit_defines.svh"

module uart_rx_line_fifo_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_strobe,
   output logic                       rsp_found,
   output logic [7:0]                 rsp_line_byte,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [urlf_pkg::LIM_W-1:0] csr_copy_limit
);

   urlf_pkg::queue_status_type     q_status;
   urlf_pkg::cmd_type              front_cmd;
   urlf_pkg::cmd_type              back_cmd;
   urlf_pkg::rsp_type              rsp;
   urlf_pkg::back_status_type      back_status;
   logic                           q_push;
   logic                           q_pop;
   logic [urlf_pkg::LIM_W-1:0]     copy_limit_ff;

   // copy limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_limit_ff <= urlf_pkg::COPY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         copy_limit_ff <= csr_copy_limit;
      end
   end

   urlf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_func    (req_func),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_cmd       (front_cmd)
   );

   urlf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .pop_cmd  (back_cmd),
      .status   (q_status)
   );

   urlf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_cmd      (back_cmd),
      .q_pop      (q_pop),
      .copy_limit (copy_limit_ff),
      .rsp        (rsp),
      .status     (back_status)
   );

   // result ports
   assign rsp_strobe    = rsp.strobe;
   assign rsp_found     = rsp.found;
   assign rsp_line_byte = rsp.line_byte;
   assign rsp_last      = rsp.last;

   // checks
   `URLF_ASSERT_SAME(a_miss_form, clock, reset, rsp_strobe && !rsp_found,
                     rsp_last && (rsp_line_byte == 8'h00))
   `URLF_ASSERT_NEXT(a_copy_gap, clock, reset, rsp_strobe && rsp_found && !rsp_last, !rsp_strobe)
   `URLF_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1,
                     back_status.fill <= urlf_pkg::CNT_W'(urlf_pkg::DEPTH))

endmodule
